[rtl/core/jtt_pkg.sv]
// Shared types and constants for the job timer table.
// Used by jtt_ctrl, jtt_dp and job_timer_table; depends on nothing.
`default_nettype none
package jtt_pkg;

    localparam int TPS_W    = 14;
    localparam int PER_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CNT_OUT_W = 4;

    localparam logic [13:0] TPS_RESET = 14'd1000;
    localparam logic [15:0] PER_RESET = 16'd1000;

    localparam logic CFG_TPS = 1'b0;
    localparam logic CFG_PER = 1'b1;

    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_ONE_SHOT = 3'd1;
    localparam logic [2:0] FN_PERIODIC = 3'd2;
    localparam logic [2:0] FN_CANCEL   = 3'd3;
    localparam logic [2:0] FN_ENABLE   = 3'd4;
    localparam logic [2:0] FN_DISABLE  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [16:0] delay_secs;
        logic [31:0] job_tag;
        logic        has_action;
        logic [15:0] job_id;
    } jtt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [31:0] fired_tag;
        logic        fired;
        logic [3:0]  active_count;
        logic        last;
    } jtt_out_t;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_EXEC, S_DUE, S_SCAN, S_OUT
    } jtt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic exec;
        logic due_eval;
        logic scan;
    } jtt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic scan_go;
        logic due_any;
        logic due_hit;
        logic due_last;
    } jtt_sts_t;

endpackage
`default_nettype wire

[rtl/core/jtt_ctrl.sv]
// Sequencing state machine for the job timer table.
// Depends on jtt_pkg; drives the datapath jtt_dp through command signals.
`default_nettype none
module jtt_ctrl #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  done,
    output logic                  scan_sel,
    output logic [IW-1:0]         idx,
    output jtt_pkg::jtt_cmd_t     cmd,
    input  wire jtt_pkg::jtt_sts_t sts
);

    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    jtt_pkg::jtt_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= jtt_pkg::S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        done       = 1'b0;
        scan_sel   = 1'b0;
        case (state_reg)
            jtt_pkg::S_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = jtt_pkg::S_PREP;
                end
            end
            jtt_pkg::S_PREP: begin
                cmd.prep = 1'b1;
                if (!sts.is_tick) begin
                    state_next = jtt_pkg::S_EXEC;
                end else if (sts.scan_go) begin
                    state_next = jtt_pkg::S_DUE;
                end else begin
                    state_next = jtt_pkg::S_OUT;
                end
            end
            jtt_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = jtt_pkg::S_OUT;
            end
            jtt_pkg::S_DUE: begin
                cmd.due_eval = 1'b1;
                idx_next     = '0;
                state_next   = sts.due_any ? jtt_pkg::S_SCAN : jtt_pkg::S_OUT;
            end
            jtt_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
                scan_sel = 1'b1;
                done     = sts.due_hit;
                // The scan stops after the highest due slot.
                if ((sts.due_hit && sts.due_last) || idx_reg == IDX_LAST) begin
                    state_next = jtt_pkg::S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            jtt_pkg::S_OUT: begin
                done       = 1'b1;
                state_next = jtt_pkg::S_IDLE;
            end
            default: begin
                state_next = jtt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != jtt_pkg::S_IDLE);
    assign idx  = idx_reg;

endmodule
`default_nettype wire

[rtl/core/jtt_dp.sv]
// Datapath of the job timer table: slot store, time and scan counters,
// configuration registers and result forming. Depends on jtt_pkg.
`default_nettype none
module jtt_dp #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [15:0]         cfg_wdata,
    input  wire jtt_pkg::jtt_in_t    item,
    input  wire jtt_pkg::jtt_cmd_t   cmd,
    input  wire logic                scan_sel,
    input  wire logic [IW-1:0]       idx,
    output jtt_pkg::jtt_sts_t        sts,
    output jtt_pkg::jtt_out_t        result
);

    localparam int CW = $clog2(SLOTS + 1);

    logic [13:0] tps_reg;
    logic [15:0] per_reg;

    logic [SLOTS-1:0] en_reg, one_reg, act_reg;
    logic [15:0] id_reg   [SLOTS];
    logic [31:0] tag_reg  [SLOTS];
    logic [31:0] ivl_reg  [SLOTS];
    logic [31:0] due_reg  [SLOTS];
    logic [31:0] now_reg;
    logic [15:0] phase_reg;
    logic [15:0] nid_reg;

    jtt_pkg::jtt_in_t in_reg;
    logic [30:0]      prod_reg;
    logic             free_ok_reg, match_ok_reg;
    logic [IW-1:0]    free_idx_reg, match_idx_reg;
    logic [1:0]       res_st_reg;
    logic [15:0]      res_id_reg;
    logic [SLOTS-1:0] dvec_reg;
    logic [CW-1:0]    cnt_after_reg;

    logic [16:0]      phase_inc;
    logic             scan_go;
    logic [SLOTS-1:0] due_comb, above;
    logic             free_ok, match_ok;
    logic [IW-1:0]    free_idx, match_idx;
    logic [CW-1:0]    cnt_now, cnt_after;
    logic             is_sched;

    assign phase_inc = {1'b0, phase_reg} + 17'd1;
    assign scan_go   = (phase_inc >= {1'b0, per_reg});
    assign is_sched  = (in_reg.func == jtt_pkg::FN_ONE_SHOT)
                    || (in_reg.func == jtt_pkg::FN_PERIODIC);

    always_comb begin
        free_ok   = 1'b0;
        free_idx  = '0;
        match_ok  = 1'b0;
        match_idx = '0;
        cnt_now   = '0;
        cnt_after = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!en_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
            if (in_reg.job_id != 16'd0 && id_reg[i] == in_reg.job_id) begin
                match_ok  = 1'b1;
                match_idx = IW'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            due_comb[i] = en_reg[i] && (now_reg >= due_reg[i]);
            above[i]    = (IW'(i) > idx);
            cnt_now     = cnt_now + CW'(en_reg[i]);
            cnt_after   = cnt_after + CW'(en_reg[i] && !(due_comb[i] && one_reg[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tps_reg   <= jtt_pkg::TPS_RESET;
            per_reg   <= jtt_pkg::PER_RESET;
            en_reg    <= '0;
            one_reg   <= '0;
            act_reg   <= '0;
            now_reg   <= '0;
            phase_reg <= '0;
            nid_reg   <= 16'd1;
            for (int i = 0; i < SLOTS; i++) begin
                id_reg[i]  <= '0;
                tag_reg[i] <= '0;
                ivl_reg[i] <= '0;
                due_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_addr == jtt_pkg::CFG_TPS) begin
                    tps_reg <= cfg_wdata[13:0];
                end else begin
                    per_reg <= cfg_wdata;
                end
            end
            if (cmd.prep && in_reg.func == jtt_pkg::FN_TICK) begin
                now_reg   <= now_reg + 32'd1;
                phase_reg <= scan_go ? 16'd0 : phase_inc[15:0];
            end
            if (cmd.exec) begin
                if (is_sched) begin
                    if (free_ok_reg) begin
                        en_reg[free_idx_reg]  <= 1'b1;
                        one_reg[free_idx_reg] <= (in_reg.func == jtt_pkg::FN_ONE_SHOT);
                        act_reg[free_idx_reg] <= in_reg.has_action;
                        id_reg[free_idx_reg]  <= nid_reg;
                        tag_reg[free_idx_reg] <= in_reg.job_tag;
                        ivl_reg[free_idx_reg] <= {1'b0, prod_reg};
                        due_reg[free_idx_reg] <= now_reg + {1'b0, prod_reg};
                        nid_reg <= (nid_reg == 16'hFFFF) ? 16'd1 : nid_reg + 16'd1;
                    end
                end else if (match_ok_reg) begin
                    case (in_reg.func)
                        jtt_pkg::FN_CANCEL: begin
                            en_reg[match_idx_reg]  <= 1'b0;
                            one_reg[match_idx_reg] <= 1'b0;
                            act_reg[match_idx_reg] <= 1'b0;
                            id_reg[match_idx_reg]  <= '0;
                            tag_reg[match_idx_reg] <= '0;
                            ivl_reg[match_idx_reg] <= '0;
                            due_reg[match_idx_reg] <= '0;
                        end
                        jtt_pkg::FN_ENABLE: begin
                            en_reg[match_idx_reg]  <= 1'b1;
                            due_reg[match_idx_reg] <= now_reg;
                        end
                        jtt_pkg::FN_DISABLE: begin
                            en_reg[match_idx_reg] <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (cmd.scan && dvec_reg[idx]) begin
                if (one_reg[idx]) begin
                    en_reg[idx] <= 1'b0;
                end else begin
                    due_reg[idx] <= now_reg + ivl_reg[idx];
                end
            end
        end
    end

    // Per-item working registers; no reset needed.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            in_reg <= item;
        end
        if (cmd.prep) begin
            prod_reg      <= 31'(in_reg.delay_secs) * 31'(tps_reg);
            free_ok_reg   <= free_ok;
            free_idx_reg  <= free_idx;
            match_ok_reg  <= match_ok;
            match_idx_reg <= match_idx;
            res_st_reg    <= jtt_pkg::ST_OK;
            res_id_reg    <= '0;
        end
        if (cmd.exec) begin
            if (is_sched) begin
                res_st_reg <= free_ok_reg ? jtt_pkg::ST_OK : jtt_pkg::ST_FULL;
                res_id_reg <= free_ok_reg ? nid_reg : 16'd0;
            end else if (in_reg.func == jtt_pkg::FN_CANCEL
                      || in_reg.func == jtt_pkg::FN_ENABLE
                      || in_reg.func == jtt_pkg::FN_DISABLE) begin
                res_st_reg <= match_ok_reg ? jtt_pkg::ST_OK : jtt_pkg::ST_NOTFOUND;
            end
        end
        if (cmd.due_eval) begin
            dvec_reg      <= due_comb;
            cnt_after_reg <= cnt_after;
        end
    end

    assign sts.is_tick  = (in_reg.func == jtt_pkg::FN_TICK);
    assign sts.scan_go  = scan_go;
    assign sts.due_any  = |due_comb;
    assign sts.due_hit  = dvec_reg[idx];
    assign sts.due_last = ~|(dvec_reg & above);

    always_comb begin
        if (scan_sel) begin
            result.status       = jtt_pkg::ST_OK;
            result.result_id    = id_reg[idx];
            result.fired        = act_reg[idx];
            result.fired_tag    = act_reg[idx] ? tag_reg[idx] : 32'd0;
            result.active_count = 4'(cnt_after_reg);
            result.last         = sts.due_last;
        end else begin
            result.status       = res_st_reg;
            result.result_id    = res_id_reg;
            result.fired        = 1'b0;
            result.fired_tag    = '0;
            result.active_count = 4'(cnt_now);
            result.last         = 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/core/job_timer_table.sv]
// Top level of the job timer table: controller plus datapath.
// Depends on jtt_pkg, jtt_ctrl and jtt_dp.
//
//   channel   ports                          beat taken when
//   ------    -----------------------------  ---------------------------
//   command   start, busy, item              start high and busy low
//   result    done, result                   done high (one cycle, no stall)
//   config    cfg_we, cfg_addr, cfg_wdata    cfg_we high
//
// A command beat passes through capture, search and multiply, update,
// then the single result beat. A tick that does not scan skips the update.
// A scanning tick evaluates every slot's due time in parallel in the due
// state, then visits slots one per cycle up to the highest due one,
// emitting one result beat per due slot, or a single beat if none is due.
// Reset clears the table, the time and phase counters and sets the next
// id to one. The receiver cannot stall, so results leave in the cycle
// they are formed.
`default_nettype none
module job_timer_table #(
    parameter int SLOTS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire jtt_pkg::jtt_in_t  item,
    output logic                   done,
    output jtt_pkg::jtt_out_t      result,
    input  wire logic              cfg_we,
    input  wire logic              cfg_addr,
    input  wire logic [15:0]       cfg_wdata
);

    // Slot index width; a single slot still gets a one-bit index.
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    jtt_pkg::jtt_cmd_t cmd;
    jtt_pkg::jtt_sts_t sts;
    logic              scan_sel;
    logic [IW-1:0]     idx;

    jtt_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .done     (done),
        .scan_sel (scan_sel),
        .idx      (idx),
        .cmd      (cmd),
        .sts      (sts)
    );

    jtt_dp #(.SLOTS(SLOTS), .IW(IW)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .scan_sel  (scan_sel),
        .idx       (idx),
        .sts       (sts),
        .result    (result)
    );

endmodule
`default_nettype wire
